// ===== rtl/rsi_pkg.sv =====
package rsi_pkg;

  localparam int IN_W = 32;
  localparam int O_W = 33;
  localparam int A_W = 66;
  localparam int B_W = 68;
  localparam int C_W = 68;
  localparam int MAG_W = 67;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DISC_W = PROD_W + 2;
  localparam int SQ_W = 68;
  localparam int RAD_W = 2 * SQ_W;
  localparam int REM_W = SQ_W + 3;
  localparam int NUM_W = 72;
  localparam int DEN_W = 67;
  localparam int DIST_W = 31;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic signed [IN_W-1:0] origin_x;
    logic signed [IN_W-1:0] origin_y;
    logic signed [IN_W-1:0] origin_z;
    logic signed [IN_W-1:0] dir_x;
    logic signed [IN_W-1:0] dir_y;
    logic signed [IN_W-1:0] dir_z;
    logic signed [IN_W-1:0] center_x;
    logic signed [IN_W-1:0] center_y;
    logic signed [IN_W-1:0] center_z;
    logic [IN_W-1:0] radius_sq;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

// ===== rtl/ray_sphere_intersect_core.sv =====
// Ray/sphere hit test in fixed point. One request enters per clock while the
// chain is not stalled, and each gives one result: registers form the quadratic
// terms, a three-stage multiplier squares b and forms a*c, a register forms the
// discriminant, a chain of 68 cells takes its square root one bit per cell, a
// register holds both roots' numerators, and a chain of 31 cells divides both
// roots one quotient bit per cell before the result register. A held result
// stalls the whole chain, so req_stall follows res_valid and res_stall.
module ray_sphere_intersect_core #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  rsi_pkg::req_t req,
  output logic res_valid,
  input  logic res_stall,
  output rsi_pkg::res_t res
);
  import rsi_pkg::*;

  localparam int DIV_W = (NUM_W + FRAC_BITS > DEN_W + 32) ? NUM_W + FRAC_BITS : DEN_W + 32;
  localparam int SP_W = 1 + A_W + B_W;
  localparam int DP_W = 3;

  logic en;
  assign en = !(res_valid && res_stall);
  assign req_stall = !en;

  logic v1, v2, v3;
  logic signed [IN_W-1:0] d1 [3];
  logic signed [O_W-1:0] o1 [3];
  logic [IN_W-1:0] r1, r2;
  logic [63:0] dd2 [3];
  logic signed [O_W+IN_W-1:0] do2 [3];
  logic [65:0] oo2 [3];
  logic [A_W-1:0] a3;
  logic signed [B_W-1:0] b3;
  logic signed [C_W-1:0] c3;
  logic [C_W-1:0] rsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign rsh = C_W'(r2) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= req.dir_x;
      d1[1] <= req.dir_y;
      d1[2] <= req.dir_z;
      o1[0] <= O_W'(req.origin_x) - O_W'(req.center_x);
      o1[1] <= O_W'(req.origin_y) - O_W'(req.center_y);
      o1[2] <= O_W'(req.origin_z) - O_W'(req.center_z);
      r1 <= req.radius_sq;
      for (int i = 0; i < 3; i++) begin
        dd2[i] <= 64'(d1[i] * d1[i]);
        do2[i] <= (O_W + IN_W)'(d1[i] * o1[i]);
        oo2[i] <= 66'(o1[i] * o1[i]);
      end
      r2 <= r1;
      a3 <= A_W'(dd2[0]) + A_W'(dd2[1]) + A_W'(dd2[2]);
      b3 <= (B_W'(do2[0]) + B_W'(do2[1]) + B_W'(do2[2])) <<< 1;
      c3 <= C_W'(oo2[0]) + C_W'(oo2[1]) + C_W'(oo2[2]) - rsh;
    end
  end

  logic [B_W-1:0] bneg;
  logic [C_W-1:0] cneg_v;
  logic [MAG_W-1:0] bmag, cmag;
  assign bneg = -b3;
  assign cneg_v = -c3;
  assign bmag = b3[B_W-1] ? bneg[MAG_W-1:0] : b3[MAG_W-1:0];
  assign cmag = c3[C_W-1] ? cneg_v[MAG_W-1:0] : c3[MAG_W-1:0];

  logic vm, vm_unused;
  logic [PROD_W-1:0] bb, ac;
  logic [A_W+B_W-1:0] abm;
  logic cneg_m;

  rsi_mul #(.W(MAG_W), .PW(A_W + B_W)) u_mul_bb (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .x(bmag), .y(bmag), .pay({a3, b3}),
    .out_valid(vm), .prod(bb), .pay_out(abm)
  );

  rsi_mul #(.W(MAG_W), .PW(1)) u_mul_ac (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .x(MAG_W'(a3)), .y(cmag), .pay(c3[C_W-1]),
    .out_valid(vm_unused), .prod(ac), .pay_out(cneg_m)
  );

  logic [DISC_W-1:0] ac4;
  logic [DISC_W-1:0] disc_next;
  logic v5;
  logic [DISC_W-1:0] disc5;
  logic [A_W+B_W-1:0] ab5;
  logic miss5;

  assign ac4 = DISC_W'(ac) << 2;
  assign disc_next = cneg_m ? DISC_W'(bb) + ac4 : DISC_W'(bb) - ac4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vm && vm_unused;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc5 <= disc_next[DISC_W-1] ? '0 : disc_next;
      miss5 <= disc_next[DISC_W-1] || (abm[A_W+B_W-1:B_W] == '0);
      ab5 <= abm;
    end
  end

  logic sv [SQ_W+1];
  logic [RAD_W-1:0] sx [SQ_W+1];
  logic [REM_W-1:0] srem [SQ_W+1];
  logic [SQ_W-1:0] sroot [SQ_W+1];
  logic [SP_W-1:0] spay [SQ_W+1];

  assign sv[0] = v5;
  assign sx[0] = disc5[RAD_W-1:0];
  assign srem[0] = '0;
  assign sroot[0] = '0;
  assign spay[0] = {miss5, ab5};

  for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
    rsi_sqrt_cell #(.PW(SP_W)) u_cell (
      .clk(clk), .rst(rst), .en(en), .in_valid(sv[k]),
      .x(sx[k]), .rem(srem[k]), .root(sroot[k]), .pay(spay[k]),
      .out_valid(sv[k+1]), .x_out(sx[k+1]), .rem_out(srem[k+1]),
      .root_out(sroot[k+1]), .pay_out(spay[k+1])
    );
  end

  logic miss_s;
  logic [A_W-1:0] a_s;
  logic signed [B_W-1:0] b_s;
  logic signed [NUM_W-1:0] nb, nn, nf;
  logic [DEN_W-1:0] den_next;
  logic [DIV_W-1:0] dlim;
  logic pos_n, pos_f;
  logic [DIV_W-1:0] nsh_n, nsh_f;

  assign miss_s = spay[SQ_W][SP_W-1];
  assign a_s = spay[SQ_W][A_W+B_W-1:B_W];
  assign b_s = spay[SQ_W][B_W-1:0];
  assign nb = -NUM_W'(b_s);
  assign nn = nb - NUM_W'(sroot[SQ_W]);
  assign nf = nb + NUM_W'(sroot[SQ_W]);
  assign den_next = DEN_W'({a_s, 1'b0});
  assign dlim = DIV_W'(den_next) << 31;
  assign pos_n = !nn[NUM_W-1] && (nn != '0);
  assign pos_f = !nf[NUM_W-1] && (nf != '0);
  assign nsh_n = pos_n ? DIV_W'(unsigned'(nn)) << FRAC_BITS : '0;
  assign nsh_f = pos_f ? DIV_W'(unsigned'(nf)) << FRAC_BITS : '0;

  logic dv [DIST_W+1];
  logic [DEN_W-1:0] dden [DIST_W+1];
  logic [DIV_W-1:0] dnn [DIST_W+1];
  logic [DIV_W-1:0] dnf [DIST_W+1];
  logic [DIST_W-1:0] dqn [DIST_W+1];
  logic [DIST_W-1:0] dqf [DIST_W+1];
  logic [DP_W-1:0] dpay [DIST_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[SQ_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dden[0] <= den_next;
      dnn[0] <= nsh_n;
      dnf[0] <= nsh_f;
      dpay[0] <= {miss_s, pos_n && (nsh_n >= dlim), pos_f && (nsh_f >= dlim)};
    end
  end

  assign dqn[0] = '0;
  assign dqf[0] = '0;

  for (genvar k = 0; k < DIST_W; k++) begin : g_div
    rsi_div_cell #(.DIV_W(DIV_W), .BIT(DIST_W - 1 - k), .PW(DP_W)) u_cell (
      .clk(clk), .rst(rst), .en(en), .in_valid(dv[k]),
      .den(dden[k]), .n_near(dnn[k]), .q_near(dqn[k]),
      .n_far(dnf[k]), .q_far(dqf[k]), .pay(dpay[k]),
      .out_valid(dv[k+1]), .den_out(dden[k+1]), .n_near_out(dnn[k+1]),
      .q_near_out(dqn[k+1]), .n_far_out(dnf[k+1]), .q_far_out(dqf[k+1]),
      .pay_out(dpay[k+1])
    );
  end

  logic [DIST_W-1:0] tn, tf;
  logic miss_d;
  assign miss_d = dpay[DIST_W][2];
  assign tn = dpay[DIST_W][1] ? DIST_MAX : dqn[DIST_W];
  assign tf = dpay[DIST_W][0] ? DIST_MAX : dqf[DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dv[DIST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.hit <= !miss_d && ((tn != '0) || (tf != '0));
      res.distance <= miss_d ? '0 : ((tn != '0) ? tn : tf);
    end
  end

endmodule

// ===== rtl/rsi_mul.sv =====
module rsi_mul #(
  parameter int W = rsi_pkg::MAG_W,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [PW-1:0] pay,
  output logic out_valid,
  output logic [2*W-1:0] prod,
  output logic [PW-1:0] pay_out
);
  localparam int N = (W + 31) / 32;
  localparam int PAD = N * 32;

  logic [PAD-1:0] xp;
  logic [PAD-1:0] yp;
  logic [63:0] pp [N][N];
  logic [PAD+31:0] row [N];
  logic [PAD+31:0] row_next [N];
  logic [2*PAD-1:0] sum_next;
  logic [2:0] vld;
  logic [PW-1:0] pay1;
  logic [PW-1:0] pay2;

  assign xp = PAD'(x);
  assign yp = PAD'(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < N; j++) begin
          pp[i][j] <= 64'(xp[32*i +: 32]) * 64'(yp[32*j +: 32]);
        end
      end
      pay1 <= pay;
      row <= row_next;
      pay2 <= pay1;
      prod <= sum_next[2*W-1:0];
      pay_out <= pay2;
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < N; j++) begin
        row_next[i] = row_next[i] + ((PAD + 32)'(pp[i][j]) << (32 * j));
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < N; i++) begin
      sum_next = sum_next + ((2 * PAD)'(row[i]) << (32 * i));
    end
  end

  assign out_valid = vld[2];

endmodule

// ===== rtl/rsi_sqrt_cell.sv =====
module rsi_sqrt_cell #(
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [rsi_pkg::RAD_W-1:0] x,
  input  logic [rsi_pkg::REM_W-1:0] rem,
  input  logic [rsi_pkg::SQ_W-1:0] root,
  input  logic [PW-1:0] pay,
  output logic out_valid,
  output logic [rsi_pkg::RAD_W-1:0] x_out,
  output logic [rsi_pkg::REM_W-1:0] rem_out,
  output logic [rsi_pkg::SQ_W-1:0] root_out,
  output logic [PW-1:0] pay_out
);
  import rsi_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic take;

  assign rem_sh = {rem[REM_W-3:0], x[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign take = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= {x[RAD_W-3:0], 2'b00};
      rem_out <= take ? rem_sh - trial : rem_sh;
      root_out <= {root[SQ_W-2:0], take};
      pay_out <= pay;
    end
  end

endmodule

// ===== rtl/rsi_div_cell.sv =====
module rsi_div_cell #(
  parameter int DIV_W = 99,
  parameter int BIT = 0,
  parameter int PW = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [rsi_pkg::DEN_W-1:0] den,
  input  logic [DIV_W-1:0] n_near,
  input  logic [rsi_pkg::DIST_W-1:0] q_near,
  input  logic [DIV_W-1:0] n_far,
  input  logic [rsi_pkg::DIST_W-1:0] q_far,
  input  logic [PW-1:0] pay,
  output logic out_valid,
  output logic [rsi_pkg::DEN_W-1:0] den_out,
  output logic [DIV_W-1:0] n_near_out,
  output logic [rsi_pkg::DIST_W-1:0] q_near_out,
  output logic [DIV_W-1:0] n_far_out,
  output logic [rsi_pkg::DIST_W-1:0] q_far_out,
  output logic [PW-1:0] pay_out
);
  import rsi_pkg::*;

  logic [DIV_W-1:0] dsh;
  logic [DIST_W-1:0] qbit;
  logic take_near;
  logic take_far;

  assign dsh = DIV_W'(den) << BIT;
  assign qbit = DIST_W'(1) << BIT;
  assign take_near = n_near >= dsh;
  assign take_far = n_far >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den;
      n_near_out <= take_near ? n_near - dsh : n_near;
      q_near_out <= take_near ? (q_near | qbit) : q_near;
      n_far_out <= take_far ? n_far - dsh : n_far;
      q_far_out <= take_far ? (q_far | qbit) : q_far;
      pay_out <= pay;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rsi_pkg::*;

  class hit_scoreboard;
    res_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function automatic logic [30:0] root_q(logic signed [139:0] num,
                                           logic signed [139:0] den);
      logic signed [139:0] n;
      if (num <= 0) return 0;
      n = num <<< 16;
      if (n >= (den <<< 31)) return DIST_MAX;
      return n / den;
    endfunction

    function automatic logic [139:0] floor_sqrt(logic [139:0] x);
      logic [139:0] r;
      logic [139:0] t;
      r = 0;
      for (int k = 69; k >= 0; k--) begin
        t = r | (140'd1 << k);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function void note_request(req_t q);
      logic signed [139:0] a, h, c, b, disc, s, o, d;
      logic [30:0] tn, tf;
      res_t r;
      a = 0;
      h = 0;
      c = 0;
      for (int i = 0; i < 3; i++) begin
        case (i)
          0: begin
            d = q.dir_x;
            o = 140'(q.origin_x) - 140'(q.center_x);
          end
          1: begin
            d = q.dir_y;
            o = 140'(q.origin_y) - 140'(q.center_y);
          end
          default: begin
            d = q.dir_z;
            o = 140'(q.origin_z) - 140'(q.center_z);
          end
        endcase
        a += d * d;
        h += d * o;
        c += o * o;
      end
      c -= $signed({108'd0, q.radius_sq}) <<< 16;
      b = h + h;
      disc = b * b - 4 * a * c;
      r = '0;
      if (disc >= 0 && a != 0) begin
        s = floor_sqrt(disc);
        tn = root_q(-b - s, a + a);
        tf = root_q(-b + s, a + a);
        if (tn != 0) begin
          r.hit = 1;
          r.distance = tn;
        end else if (tf != 0) begin
          r.hit = 1;
          r.distance = tf;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0d distance=%0d", $time, got.hit,
                 got.distance);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, e.hit, got.hit);
        errors++;
      end
      if (got.distance !== e.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, e.distance,
                 got.distance);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 0;
  res_t res;
  hit_scoreboard sb = new();
  int cycles = 0;
  int hold_left = 0;
  bit sending_done = 0;

  ray_sphere_intersect_core DUT (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb_top: done, errors");
      $finish;
    end
    if (!rst && req_valid && !req_stall) sb.note_request(req);
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_stall <= 1;
    end else if ($urandom_range(0, 99) < 30) begin
      hold_left = gap_len();
      res_stall <= hold_left > 0;
      if (hold_left > 0) hold_left = hold_left - 1;
    end else begin
      res_stall <= 0;
    end
  end

  task automatic send_request(req_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(negedge clk);
    end
    req <= q;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_coord(int scale);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> scale;
  endfunction

  function automatic req_t aimed_request();
    req_t q;
    int sc;
    sc = $urandom_range(6, 14);
    q.center_x = rnd_coord(sc);
    q.center_y = rnd_coord(sc);
    q.center_z = rnd_coord(sc);
    q.origin_x = rnd_coord(sc);
    q.origin_y = rnd_coord(sc);
    q.origin_z = rnd_coord(sc);
    q.dir_x = $signed(q.center_x - q.origin_x) >>> $urandom_range(0, 8);
    q.dir_y = $signed(q.center_y - q.origin_y) >>> $urandom_range(0, 8);
    q.dir_z = $signed(q.center_z - q.origin_z) >>> $urandom_range(0, 8);
    q.radius_sq = $urandom >> $urandom_range(0, 12);
    return q;
  endfunction

  task automatic directed();
    req_t q;
    q = '0;
    send_request(q);
    q.dir_x = 32'h0001_0000;
    q.center_x = 32'h000A_0000;
    q.radius_sq = 32'h0004_0000;
    send_request(q);
    q.center_x = 32'h0000_8000;
    send_request(q);
    q.center_x = -32'sh000A_0000;
    send_request(q);
    q.center_x = 32'h000A_0000;
    q.center_y = 32'h0002_0000;
    send_request(q);
    q.center_y = 32'h0003_0000;
    send_request(q);
    q.dir_x = 32'h0000_0001;
    q.center_y = 0;
    send_request(q);
    q = '1;
    send_request(q);
    q = {10{32'h8000_0000}};
    send_request(q);
    q = {10{32'h7FFF_FFFF}};
    send_request(q);
    q.origin_x = 32'h8000_0000;
    q.dir_x = 32'h7FFF_FFFF;
    q.radius_sq = 32'hFFFF_FFFF;
    send_request(q);
    q = '0;
    q.dir_y = 32'h8000_0000;
    q.radius_sq = 32'hFFFF_FFFF;
    send_request(q);
    q.center_y = 32'h8000_0000;
    q.origin_y = 32'h7FFF_FFFF;
    send_request(q);
  endtask

  initial begin
    req_t q;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    directed();
    for (int i = 0; i < 1550; i++) begin
      if (i == 700) begin
        req_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      if ($urandom_range(0, 3) == 0) begin
        q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom};
      end else begin
        q = aimed_request();
      end
      send_request(q);
    end
    req_valid <= 0;
    sending_done = 1;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule

// ===== ray_sphere_intersect_core.f =====
rtl/rsi_pkg.sv
rtl/rsi_mul.sv
rtl/rsi_sqrt_cell.sv
rtl/rsi_div_cell.sv
rtl/ray_sphere_intersect_core.sv
bench/tb_top.sv
